@@ design/pic_pkg.sv @@
package pic_pkg;

  // coordinate width of the circle points and query point
  localparam int COORD_BITS = 16;

  localparam int CFG_IDX_W  = 3;

  // differences of two coordinates
  localparam int DIFF_W     = COORD_BITS + 1;
  // products of two differences (squares, cross terms, orientation terms)
  localparam int PROD_W     = 2 * DIFF_W;
  // sum of two squares, unsigned
  localparam int LIFT_W     = 2 * COORD_BITS + 1;
  // 2x2 minor, signed
  localparam int CROSS_W    = PROD_W;

  // lift and cross are each split at SPLIT_W for the partial products
  localparam int SPLIT_W    = COORD_BITS + 1;
  localparam int LIFT_HI_W  = LIFT_W - SPLIT_W;
  localparam int CROSS_HI_W = CROSS_W - SPLIT_W;

  localparam int PP00_W     = 2 * SPLIT_W;
  localparam int PP10_W     = LIFT_HI_W + SPLIT_W;
  localparam int PP01_W     = SPLIT_W + 1 + CROSS_HI_W;
  localparam int PP11_W     = LIFT_HI_W + 1 + CROSS_HI_W;

  // full determinant, three terms of lift * cross
  localparam int DET_W      = 4 * COORD_BITS + 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [LIFT_W-1:0]     lift_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    POS_INSIDE   = 2'd0,
    POS_BOUNDARY = 2'd1,
    POS_OUTSIDE  = 2'd2
  } position_t;

endpackage

@@ design/point_in_circle_test_top.sv @@
// Channel   Ports                                   Transfer
// --------  --------------------------------------  ------------------------------
// query     start, busy, in_query_x, in_query_y     edge with start && !busy
// result    out_valid, out_position                 edge ending the out_valid cycle
// config    cfg_valid, cfg_ready, cfg_index,        edge with cfg_valid && cfg_ready
//           cfg_data
//
// One query per cycle, sustained; busy is never raised.
// The result of a query passes through six register stages (stage 1 to stage 6) before
// it reaches the result ports, where it is transferred at the edge ending out_valid.
// rst_n is synchronous, active low; it clears the circle points to zero and drops
// every query in flight.
// The receiver cannot stall, so the pipeline never holds; nothing waits at the output.
module point_in_circle_test_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  pic_pkg::coord_t          in_query_x,
  input  pic_pkg::coord_t          in_query_y,
  output logic                     out_valid,
  output logic [1:0]               out_position,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  pic_pkg::cfg_idx_t        cfg_index,
  input  pic_pkg::coord_t          cfg_data
);
  import pic_pkg::*;

  // ---------------------------------------------------------------------------
  // Circle points. Indices past C_Y are dropped.
  // ---------------------------------------------------------------------------
  coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_X: ax_r <= cfg_data;
        REG_A_Y: ay_r <= cfg_data;
        REG_B_X: bx_r <= cfg_data;
        REG_B_Y: by_r <= cfg_data;
        REG_C_X: cx_r <= cfg_data;
        REG_C_Y: cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_xfer;
  assign in_xfer = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: translate A, B, C by the query point; edge vectors for orientation.
  // Swapping B and C only negates the determinant, so no swap is done: the
  // orientation sign is carried along and flips the final sign instead.
  // Lanes: 0 = A, 1 = B, 2 = C.
  // ---------------------------------------------------------------------------
  logic  v1_r;
  diff_t dx_r [3];
  diff_t dy_r [3];
  diff_t e1_r, e2_r, e3_r, e4_r;
  diff_t dx_nxt [3];
  diff_t dy_nxt [3];

  always_comb begin
    dx_nxt[0] = DIFF_W'(ax_r) - DIFF_W'(in_query_x);
    dy_nxt[0] = DIFF_W'(ay_r) - DIFF_W'(in_query_y);
    dx_nxt[1] = DIFF_W'(bx_r) - DIFF_W'(in_query_x);
    dy_nxt[1] = DIFF_W'(by_r) - DIFF_W'(in_query_y);
    dx_nxt[2] = DIFF_W'(cx_r) - DIFF_W'(in_query_x);
    dy_nxt[2] = DIFF_W'(cy_r) - DIFF_W'(in_query_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_xfer;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dx_r[i] <= dx_nxt[i];
      dy_r[i] <= dy_nxt[i];
    end
    e1_r <= DIFF_W'(bx_r) - DIFF_W'(ax_r);
    e2_r <= DIFF_W'(cy_r) - DIFF_W'(ay_r);
    e3_r <= DIFF_W'(by_r) - DIFF_W'(ay_r);
    e4_r <= DIFF_W'(cx_r) - DIFF_W'(ax_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: all difference products.
  // ---------------------------------------------------------------------------
  logic  v2_r;
  prod_t sqx_r [3];
  prod_t sqy_r [3];
  prod_t crp_r [3];
  prod_t crm_r [3];
  prod_t o1_r, o2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sqx_r[i] <= PROD_W'(dx_r[i]) * PROD_W'(dx_r[i]);
      sqy_r[i] <= PROD_W'(dy_r[i]) * PROD_W'(dy_r[i]);
    end
    // minor i pairs the two other lanes in cyclic order
    crp_r[0] <= PROD_W'(dx_r[1]) * PROD_W'(dy_r[2]);
    crm_r[0] <= PROD_W'(dx_r[2]) * PROD_W'(dy_r[1]);
    crp_r[1] <= PROD_W'(dx_r[2]) * PROD_W'(dy_r[0]);
    crm_r[1] <= PROD_W'(dx_r[0]) * PROD_W'(dy_r[2]);
    crp_r[2] <= PROD_W'(dx_r[0]) * PROD_W'(dy_r[1]);
    crm_r[2] <= PROD_W'(dx_r[1]) * PROD_W'(dy_r[0]);
    o1_r     <= PROD_W'(e1_r) * PROD_W'(e2_r);
    o2_r     <= PROD_W'(e3_r) * PROD_W'(e4_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: lifts, 2x2 minors, orientation sign.
  // ---------------------------------------------------------------------------
  logic   v3_r;
  lift_t  lift_r  [3];
  cross_t cross_r [3];
  logic   oneg3_r;
  prod_t  orient_nxt;
  prod_t  lsum_nxt [3];

  always_comb begin
    orient_nxt = o1_r - o2_r;
    for (int i = 0; i < 3; i++) begin
      lsum_nxt[i] = sqx_r[i] + sqy_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lift_r[i]  <= lsum_nxt[i][LIFT_W-1:0];
      cross_r[i] <= crp_r[i] - crm_r[i];
    end
    oneg3_r <= orient_nxt[PROD_W-1];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: lift * cross as four partial products per lane.
  // ---------------------------------------------------------------------------
  logic                     v4_r;
  logic                     oneg4_r;
  logic        [PP00_W-1:0] pp00_r [3];
  logic        [PP10_W-1:0] pp10_r [3];
  logic signed [PP01_W-1:0] pp01_r [3];
  logic signed [PP11_W-1:0] pp11_r [3];

  logic        [SPLIT_W-1:0]    llo_nxt [3];
  logic        [LIFT_HI_W-1:0]  lhi_nxt [3];
  logic        [SPLIT_W-1:0]    clo_nxt [3];
  logic signed [CROSS_HI_W-1:0] chi_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      llo_nxt[i] = lift_r[i][SPLIT_W-1:0];
      lhi_nxt[i] = lift_r[i][LIFT_W-1:SPLIT_W];
      clo_nxt[i] = cross_r[i][SPLIT_W-1:0];
      chi_nxt[i] = signed'(cross_r[i][CROSS_W-1:SPLIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pp00_r[i] <= PP00_W'(llo_nxt[i]) * PP00_W'(clo_nxt[i]);
      pp10_r[i] <= PP10_W'(lhi_nxt[i]) * PP10_W'(clo_nxt[i]);
      pp01_r[i] <= PP01_W'(signed'({1'b0, llo_nxt[i]})) * PP01_W'(chi_nxt[i]);
      pp11_r[i] <= PP11_W'(signed'({1'b0, lhi_nxt[i]})) * PP11_W'(chi_nxt[i]);
    end
    oneg4_r <= oneg3_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: recombine each lane's partial products. Intermediate wrap in DET_W
  // is harmless: the exact result fits.
  // ---------------------------------------------------------------------------
  logic v5_r;
  logic oneg5_r;
  det_t term_r   [3];
  det_t term_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term_nxt[i] = DET_W'(signed'({1'b0, pp00_r[i]}))
                  + (DET_W'(signed'({1'b0, pp10_r[i]})) <<< SPLIT_W)
                  + (DET_W'(pp01_r[i]) <<< SPLIT_W)
                  + (DET_W'(pp11_r[i]) <<< (2 * SPLIT_W));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      term_r[i] <= term_nxt[i];
    end
    oneg5_r <= oneg4_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: determinant sign, corrected for a clockwise triangle.
  // ---------------------------------------------------------------------------
  det_t      det_nxt;
  position_t pos_nxt;
  logic      out_valid_r;
  position_t out_position_r;

  always_comb begin
    det_nxt = term_r[0] + term_r[1] + term_r[2];
    priority if (det_nxt == '0) begin
      pos_nxt = POS_BOUNDARY;
    end else if (det_nxt[DET_W-1] ^ oneg5_r) begin
      pos_nxt = POS_OUTSIDE;
    end else begin
      pos_nxt = POS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    out_position_r <= pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // every result traces back to an earlier query transfer
  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, 6))
    else $error("result without a matching query");

  // query on point A: duplicate rows, determinant must vanish
  a_query_on_a: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && dx_r[0] == '0 && dy_r[0] == '0)
      |-> ##5 (out_valid && out_position == POS_BOUNDARY))
    else $error("query on circle point not reported as boundary");

  // A and B coincide: duplicate rows, determinant must vanish
  a_a_equals_b: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && dx_r[0] == dx_r[1] && dy_r[0] == dy_r[1])
      |-> ##5 (out_valid && out_position == POS_BOUNDARY))
    else $error("coincident circle points not reported as boundary");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pic_pkg::*;

  // 128 bits comfortably holds the full 4x4 determinant for 16-bit coords
  typedef logic signed [127:0] wide_t;

  localparam coord_t   COORD_MAX        = coord_t'(2 ** (COORD_BITS - 1) - 1);
  localparam coord_t   COORD_MIN        = coord_t'(-(2 ** (COORD_BITS - 1)));
  // indexes past the last circle register: writes are dropped by the block
  localparam cfg_idx_t CFG_IDX_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_IDX_SPARE_HI = 3'd7;
  localparam int       WATCHDOG_LIMIT   = 2000;
  localparam int       DRAIN_CYCLES     = 12;

  // Integer points on the circle of radius 5 around the origin. Scaled and
  // shifted, they give circles with exact boundary hits.
  localparam int RING_X [12] = '{5, 4, 3, 0, -3, -4, -5, -4, -3, 0, 3, 4};
  localparam int RING_Y [12] = '{0, 3, 4, 5, 4, 3, 0, -3, -4, -5, -4, -3};

  // Circle registers as the block should hold them, plus the positions
  // predicted for queries still in the pipe.
  class circle_scoreboard;
    coord_t    circle_pt [6];
    position_t expected_positions [$];
    int        errors;

    function new();
      foreach (circle_pt[i]) circle_pt[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, coord_t data);
      if (idx <= REG_C_Y) circle_pt[idx] = data;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // Sign of the incircle determinant, taken in its translated 3x3 form
    function position_t incircle_position(coord_t qx, coord_t qy);
      longint ax, ay, bx, by, cx, cy, tmp, orient;
      longint adx, ady, bdx, bdy, cdx, cdy;
      wide_t  det;
      ax = circle_pt[REG_A_X];
      ay = circle_pt[REG_A_Y];
      bx = circle_pt[REG_B_X];
      by = circle_pt[REG_B_Y];
      cx = circle_pt[REG_C_X];
      cy = circle_pt[REG_C_Y];
      // clockwise triangle: swap B and C so the sign convention holds
      orient = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      if (orient < 0) begin
        tmp = bx; bx = cx; cx = tmp;
        tmp = by; by = cy; cy = tmp;
      end
      adx = ax - qx; ady = ay - qy;
      bdx = bx - qx; bdy = by - qy;
      cdx = cx - qx; cdy = cy - qy;
      det = wide_t'(adx * adx + ady * ady) * wide_t'(bdx * cdy - cdx * bdy)
          + wide_t'(bdx * bdx + bdy * bdy) * wide_t'(cdx * ady - adx * cdy)
          + wide_t'(cdx * cdx + cdy * cdy) * wide_t'(adx * bdy - bdx * ady);
      if (det > 0)       return POS_INSIDE;
      else if (det == 0) return POS_BOUNDARY;
      else               return POS_OUTSIDE;
    endfunction

    function void record_query(coord_t qx, coord_t qy);
      expected_positions.push_back(incircle_position(qx, qy));
    endfunction

    function void check_position(logic [1:0] actual);
      position_t want;
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result, position %0d, nothing expected", $time, actual);
        errors++;
        return;
      end
      want = expected_positions.pop_front();
      if (actual !== want) begin
        $display("%0t: position mismatch, expected %0d (%s), actual %0d",
                 $time, want, want.name(), actual);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  coord_t   in_query_x;
  coord_t   in_query_y;
  logic     out_valid;
  logic [1:0] out_position;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  coord_t   cfg_data;

  circle_scoreboard sb = new();
  int sender_idle_pct;
  int idle_cycles;

  point_in_circle_test_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_query_x   (in_query_x),
    .in_query_y   (in_query_y),
    .out_valid    (out_valid),
    .out_position (out_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One monitor for all three channels, so the order of register update,
  // prediction and check within an edge is fixed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy)         sb.record_query(in_query_x, in_query_y);
      if (out_valid)              sb.check_position(out_position);
    end
  end

  // Watchdog: cycles in a row with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transfer for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Wait for every predicted result, read off the falling edge so the
  // monitor has settled, then go back to a rising edge for driving.
  task automatic drain();
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Holds valid until the write transfers; caller lowers cfg_valid.
  task automatic cfg_put(cfg_idx_t idx, coord_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // New circle, only with the pipe empty. Optionally a write to an unused
  // index first, which must leave the circle alone.
  task automatic load_circle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                             coord_t cx, coord_t cy, bit spare_write);
    start <= 1'b0;
    drain();
    if (spare_write)
      cfg_put(cfg_idx_t'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)), rand_coord());
    cfg_put(REG_A_X, ax);
    cfg_put(REG_A_Y, ay);
    cfg_put(REG_B_X, bx);
    cfg_put(REG_B_Y, by);
    cfg_put(REG_C_X, cx);
    cfg_put(REG_C_Y, cy);
    cfg_valid <= 1'b0;
  endtask

  // Random idle gap (with junk on the data ports), then one query transfer.
  task automatic send_query(coord_t qx, coord_t qy);
    while ($urandom_range(99) < sender_idle_pct) begin
      start      <= 1'b0;
      in_query_x <= coord_t'($urandom);
      in_query_y <= coord_t'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    in_query_x <= qx;
    in_query_y <= qy;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int     kind, items, pick, ctr_x, ctr_y, scale, dir_x, dir_y, qx, qy;
    coord_t pt_x [3];
    coord_t pt_y [3];

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_query_x      <= '0;
    in_query_y      <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_A_X;
    cfg_data        <= '0;
    sender_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset circle: all three points coincide at the origin
    send_query(0, 0);
    send_query(COORD_MIN, COORD_MAX);

    // counterclockwise unit circle, with a dropped write to a spare index
    load_circle(1, 0, 0, 1, -1, 0, 1'b1);
    send_query(0, 0);
    send_query(0, -1);
    send_query(2, 2);
    send_query(COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, COORD_MAX);

    // same circle, clockwise order: block must flip the determinant sign
    load_circle(1, 0, -1, 0, 0, 1, 1'b0);
    send_query(0, 0);
    send_query(0, -1);
    send_query(2, 2);
    send_query(COORD_MAX, COORD_MIN);

    // collinear circle points
    load_circle(0, 0, 1, 1, 2, 2, 1'b0);
    send_query(5, 5);
    send_query(5, 6);
    send_query(COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, COORD_MAX);

    // corners of the full coordinate square: widest terms in the determinant
    load_circle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_query(COORD_MIN, COORD_MAX);
    send_query(0, 0);
    send_query(COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, 0);

    // coincident points away from the origin
    load_circle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_query(0, 0);
    send_query(COORD_MAX, COORD_MAX);

    // --- random phases: circle shape by kind, sender idling by phase ---
    for (int phase = 0; phase < 20; phase++) begin
      kind  = phase % 4;
      items = $urandom_range(40, 24);
      case (phase % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 53;
        default: sender_idle_pct = 9;
      endcase
      ctr_x = $urandom_range(20000) - 10000;
      ctr_y = $urandom_range(20000) - 10000;
      scale = ($urandom_range(3) == 0) ? $urandom_range(4000, 1) : $urandom_range(20, 1);
      dir_x = $urandom_range(14) - 7;
      dir_y = $urandom_range(14) - 7;
      for (int i = 0; i < 3; i++) begin
        case (kind)
          0: begin
            pt_x[i] = rand_coord();
            pt_y[i] = rand_coord();
          end
          1: begin
            pick    = $urandom_range(11);
            pt_x[i] = coord_t'(ctr_x + scale * RING_X[pick]);
            pt_y[i] = coord_t'(ctr_y + scale * RING_Y[pick]);
          end
          2: begin
            pick    = (i == 0) ? 0 : $urandom_range(200) - 100;
            pt_x[i] = coord_t'(ctr_x / 10 + pick * dir_x);
            pt_y[i] = coord_t'(ctr_y / 10 + pick * dir_y);
          end
          default: begin
            pt_x[i] = coord_t'($urandom_range(8) - 4);
            pt_y[i] = coord_t'($urandom_range(8) - 4);
          end
        endcase
      end
      load_circle(pt_x[0], pt_y[0], pt_x[1], pt_y[1], pt_x[2], pt_y[2],
                  $urandom_range(3) == 0);

      for (int n = 0; n < items; n++) begin
        qx = rand_coord();
        qy = rand_coord();
        pick = $urandom_range(3);
        case (kind)
          0: if (pick == 0) begin
            // one of the circle points: always on the boundary
            pick = $urandom_range(2);
            qx   = pt_x[pick];
            qy   = pt_y[pick];
          end
          1: if (pick == 0) begin
            pick = $urandom_range(11);
            qx   = ctr_x + scale * RING_X[pick];
            qy   = ctr_y + scale * RING_Y[pick];
          end else if (pick == 1) begin
            qx = ctr_x + $urandom_range(10 * scale) - 5 * scale;
            qy = ctr_y + $urandom_range(10 * scale) - 5 * scale;
          end
          2: if (pick < 2) begin
            // on the common line
            pick = $urandom_range(2000) - 1000;
            qx   = ctr_x / 10 + pick * dir_x;
            qy   = ctr_y / 10 + pick * dir_y;
          end
          default: if (pick != 0) begin
            qx = $urandom_range(12) - 6;
            qy = $urandom_range(12) - 6;
          end
        endcase
        send_query(coord_t'(qx), coord_t'(qy));
      end
    end

    start <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pic_pkg.sv
design/point_in_circle_test_top.sv
tb/testbench.sv
